FILE: src/echi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// echi_pkg: embedded controller host interface definitions
// Operation codes, controller command bytes, status bits, transaction
// phases and event codes shared by the host interface core.
// ----------------------------------------------------------------------------
package echi_pkg;

	localparam int unsigned OP_W    = 3;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned EV_W    = 2;
	localparam int unsigned PHASE_W = 2;
	localparam int unsigned RAM_AW  = 8;
	localparam int unsigned RAM_DEPTH = 1 << RAM_AW;

	typedef logic [OP_W-1:0]    op_t;
	typedef logic [BYTE_W-1:0]  byte_t;
	typedef logic [EV_W-1:0]    event_t;
	typedef logic [PHASE_W-1:0] phase_t;

	// host-side operations
	localparam op_t OP_STATUS_READ = 3'd0;
	localparam op_t OP_DATA_READ   = 3'd1;
	localparam op_t OP_CMD_WRITE   = 3'd2;
	localparam op_t OP_DATA_WRITE  = 3'd3;
	localparam op_t OP_TICK        = 3'd4;

	// controller command bytes
	localparam byte_t EC_CMD_READ  = 8'h80;
	localparam byte_t EC_CMD_WRITE = 8'h81;

	// status register bit positions
	localparam int unsigned STATUS_OBF_BIT = 0;
	localparam int unsigned STATUS_IBF_BIT = 1;
	localparam int unsigned STATUS_CMD_BIT = 3;

	// transaction phases
	localparam phase_t PH_IDLE       = 2'd0;
	localparam phase_t PH_READ_ADDR  = 2'd1;
	localparam phase_t PH_WRITE_ADDR = 2'd2;
	localparam phase_t PH_WRITE_VAL  = 2'd3;

	// event codes
	localparam event_t EV_OK          = 2'd0;
	localparam event_t EV_OVERRUN     = 2'd1;
	localparam event_t EV_UNKNOWN_CMD = 2'd2;
	localparam event_t EV_UNEXPECTED  = 2'd3;

endpackage : echi_pkg
`default_nettype wire

FILE: src/embedded_controller_host_interface_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// embedded_controller_host_interface_core: controller side of the EC host port
// Command/status and data port emulation backed by a 256-byte controller RAM,
// with read (0x80) and write (0x81) transactions and event reporting.
// ----------------------------------------------------------------------------
// Each transfer on the input channel is one host operation: status read, data
// read, command write, data write, or a controller tick that consumes the
// pending input byte. Every operation yields exactly one result transfer
// (read_byte, event_code), in order. The accept cycle of an operation issues
// the read of the controller RAM at the pending input byte, and the execute
// cycle takes the registered read data, updates the port state and, for a
// write-value byte, writes the RAM. The RAM port pair is one registered read
// and one write. A result sits in an output register, so the next operation
// is accepted while it waits. Input is held off in every execute cycle, and
// the execute cycle repeats for as long as the output register is still
// occupied and stalled. The RAM reads as all zeros after reset with no
// clearing pass: a per-entry valid bit, cleared by reset, masks entries not
// yet written since reset.
module embedded_controller_host_interface_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output      logic                         in_stall,
	input  wire logic [echi_pkg::OP_W-1:0]    cmd,
	input  wire logic [echi_pkg::BYTE_W-1:0]  host_byte,
	output      logic                         out_valid,
	input  wire logic                         out_stall,
	output      logic [echi_pkg::BYTE_W-1:0]  read_byte,
	output      logic [echi_pkg::EV_W-1:0]    event_code
);
	import echi_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;

	// operation captured at accept
	op_t   op_s1;
	byte_t byte_s1;

	// host port state
	byte_t  input_buf_q;
	logic   input_is_cmd_q;
	logic   input_full_q;
	byte_t  output_buf_q;
	logic   output_full_q;
	phase_t phase_q;
	byte_t  addr_latch_q;

	// result register
	logic   out_valid_q;
	byte_t  read_byte_q;
	event_t event_code_q;

	// controller RAM and its valid bits
	byte_t                 ec_ram [RAM_DEPTH];
	logic [RAM_DEPTH-1:0]  ram_vld_q;
	byte_t                 ram_rd_s1;
	logic                  ram_vld_s1;

	logic   accept;
	logic   commit;
	byte_t  ram_data;

	// next values computed in the execute cycle
	byte_t  rd_nx;
	event_t ev_nx;
	byte_t  input_buf_nx;
	logic   input_is_cmd_nx;
	logic   input_full_nx;
	byte_t  output_buf_nx;
	logic   output_full_nx;
	phase_t phase_nx;
	byte_t  addr_latch_nx;
	logic   ram_we;

	assign in_stall   = (state_q != ST_IDLE);
	assign accept     = in_valid && !in_stall;
	// retire only when the result register is free or drains this cycle
	assign commit     = (state_q == ST_EXEC) && (!out_valid_q || !out_stall);
	assign out_valid  = out_valid_q;
	assign read_byte  = read_byte_q;
	assign event_code = event_code_q;

	// never-written entries read as zero
	assign ram_data = ram_vld_s1 ? ram_rd_s1 : '0;

	always_comb begin
		rd_nx           = '0;
		ev_nx           = EV_OK;
		input_buf_nx    = input_buf_q;
		input_is_cmd_nx = input_is_cmd_q;
		input_full_nx   = input_full_q;
		output_buf_nx   = output_buf_q;
		output_full_nx  = output_full_q;
		phase_nx        = phase_q;
		addr_latch_nx   = addr_latch_q;
		ram_we          = 1'b0;

		unique case (op_s1)
			OP_STATUS_READ: begin
				rd_nx[STATUS_OBF_BIT] = output_full_q;
				rd_nx[STATUS_IBF_BIT] = input_full_q;
				rd_nx[STATUS_CMD_BIT] = input_is_cmd_q;
			end
			OP_DATA_READ: begin
				rd_nx          = output_buf_q;
				output_full_nx = 1'b0;
			end
			OP_CMD_WRITE, OP_DATA_WRITE: begin
				// drop the new byte if the previous one is still pending
				if (input_full_q) begin
					ev_nx = EV_OVERRUN;
				end else begin
					input_buf_nx    = byte_s1;
					input_is_cmd_nx = (op_s1 == OP_CMD_WRITE);
					input_full_nx   = 1'b1;
				end
			end
			OP_TICK: begin
				if (input_full_q) begin
					input_full_nx = 1'b0;
					if (input_is_cmd_q) begin
						// a command always ends any open transaction and, if known, starts a new one
						if (input_buf_q == EC_CMD_READ) begin
							phase_nx = PH_READ_ADDR;
						end else if (input_buf_q == EC_CMD_WRITE) begin
							phase_nx = PH_WRITE_ADDR;
						end else begin
							phase_nx = PH_IDLE;
							ev_nx    = EV_UNKNOWN_CMD;
						end
					end else begin
						unique case (phase_q)
							PH_READ_ADDR: begin
								output_buf_nx  = ram_data;
								output_full_nx = 1'b1;
								phase_nx       = PH_IDLE;
							end
							PH_WRITE_ADDR: begin
								addr_latch_nx = input_buf_q;
								phase_nx      = PH_WRITE_VAL;
							end
							PH_WRITE_VAL: begin
								ram_we   = 1'b1;
								phase_nx = PH_IDLE;
							end
							default: begin
								ev_nx = EV_UNEXPECTED;
							end
						endcase
					end
				end
			end
			default: begin
			end
		endcase
	end

	// state machine, port state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			op_s1          <= OP_STATUS_READ;
			byte_s1        <= '0;
			input_buf_q    <= '0;
			input_is_cmd_q <= 1'b0;
			input_full_q   <= 1'b0;
			output_buf_q   <= '0;
			output_full_q  <= 1'b0;
			phase_q        <= PH_IDLE;
			addr_latch_q   <= '0;
			out_valid_q    <= 1'b0;
			read_byte_q    <= '0;
			event_code_q   <= EV_OK;
		end else begin
			// drop the result once taken, unless a new one lands this cycle
			if (out_valid_q && !out_stall && !commit) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_s1   <= cmd;
						byte_s1 <= host_byte;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (commit) begin
						input_buf_q    <= input_buf_nx;
						input_is_cmd_q <= input_is_cmd_nx;
						input_full_q   <= input_full_nx;
						output_buf_q   <= output_buf_nx;
						output_full_q  <= output_full_nx;
						phase_q        <= phase_nx;
						addr_latch_q   <= addr_latch_nx;
						out_valid_q    <= 1'b1;
						read_byte_q    <= rd_nx;
						event_code_q   <= ev_nx;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// RAM valid bits: set on first write, read alongside the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_vld_q  <= '0;
			ram_vld_s1 <= 1'b0;
		end else begin
			if (commit && ram_we) begin
				ram_vld_q[addr_latch_q] <= 1'b1;
			end
			if (accept) begin
				ram_vld_s1 <= ram_vld_q[input_buf_q];
			end
		end
	end

	// controller RAM: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (commit && ram_we) begin
			ec_ram[addr_latch_q] <= input_buf_q;
		end
		if (accept) begin
			ram_rd_s1 <= ec_ram[input_buf_q];
		end
	end

`ifndef SYNTH
	a_read_no_event: assert property (@(posedge clk) disable iff (!arst_n)
		commit && (op_s1 == OP_STATUS_READ || op_s1 == OP_DATA_READ) |-> ev_nx == EV_OK)
		else $error("host read reported an event");

	a_data_read_clears_obf: assert property (@(posedge clk) disable iff (!arst_n)
		commit && op_s1 == OP_DATA_READ |=> !output_full_q)
		else $error("data read left output-full set");

	a_write_val_order: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_WRITE_VAL && $past(phase_q) != PH_WRITE_VAL
		|-> $past(phase_q) == PH_WRITE_ADDR)
		else $error("write-value phase entered without an address");

	a_ram_write_phase: assert property (@(posedge clk) disable iff (!arst_n)
		commit && ram_we |-> phase_q == PH_WRITE_VAL && op_s1 == OP_TICK && input_full_q)
		else $error("RAM written outside a write-value tick");

	a_stall_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall && !out_valid_q || in_stall)
		else $error("input accepted back to back");
`endif

endmodule : embedded_controller_host_interface_core
`default_nettype wire

FILE: tb/echi_port_checker.sv
// ----------------------------------------------------------------------------
// echi_port_checker: result checker for the EC host interface core
// Watches both channels, predicts the result of every accepted host
// operation and compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module echi_port_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	input  wire logic                          in_stall,
	input  wire logic [echi_pkg::OP_W-1:0]     cmd,
	input  wire logic [echi_pkg::BYTE_W-1:0]   host_byte,
	input  wire logic                          out_valid,
	input  wire logic                          out_stall,
	input  wire logic [echi_pkg::BYTE_W-1:0]   read_byte,
	input  wire logic [echi_pkg::EV_W-1:0]     event_code,
	output int                                 mismatches,
	output int                                 pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import echi_pkg::*;

	typedef struct packed {
		byte_t  rd;
		event_t ev;
	} port_result_t;

	// predicted controller state
	byte_t  ram [RAM_DEPTH];
	byte_t  in_buf;
	bit     in_is_cmd;
	bit     in_full;
	byte_t  out_buf;
	bit     out_full;
	phase_t phase;
	byte_t  addr_latch;

	port_result_t awaited_results [$];
	port_result_t want;
	port_result_t fresh;

	task automatic apply_host_op(input op_t op, input byte_t b, output port_result_t r);
		r = '0;
		case (op)
			OP_STATUS_READ: begin
				r.rd[STATUS_OBF_BIT] = out_full;
				r.rd[STATUS_IBF_BIT] = in_full;
				r.rd[STATUS_CMD_BIT] = in_is_cmd;
			end
			OP_DATA_READ: begin
				r.rd = out_buf;
				out_full = 1'b0;
			end
			OP_CMD_WRITE, OP_DATA_WRITE: begin
				if (in_full) begin
					r.ev = EV_OVERRUN;
				end else begin
					in_buf = b;
					in_is_cmd = (op == OP_CMD_WRITE);
					in_full = 1'b1;
				end
			end
			OP_TICK: begin
				if (in_full) begin
					in_full = 1'b0;
					if (in_is_cmd) begin
						if (in_buf == EC_CMD_READ) begin
							phase = PH_READ_ADDR;
						end else if (in_buf == EC_CMD_WRITE) begin
							phase = PH_WRITE_ADDR;
						end else begin
							phase = PH_IDLE;
							r.ev = EV_UNKNOWN_CMD;
						end
					end else begin
						case (phase)
							PH_READ_ADDR: begin
								out_buf = ram[in_buf];
								out_full = 1'b1;
								phase = PH_IDLE;
							end
							PH_WRITE_ADDR: begin
								addr_latch = in_buf;
								phase = PH_WRITE_VAL;
							end
							PH_WRITE_VAL: begin
								ram[addr_latch] = in_buf;
								phase = PH_IDLE;
							end
							default: r.ev = EV_UNEXPECTED;
						endcase
					end
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (ram[i]) ram[i] = '0;
			in_buf = '0;
			in_is_cmd = 1'b0;
			in_full = 1'b0;
			out_buf = '0;
			out_full = 1'b0;
			phase = PH_IDLE;
			addr_latch = '0;
			awaited_results.delete();
			mismatches = 0;
		end else begin
			// results are always older than an operation accepted at the same edge
			if (out_valid && !out_stall) begin
				if (awaited_results.size() == 0) begin
					$display("%0t: result with nothing awaited: read_byte %02h event_code %0d",
						$time, read_byte, event_code);
					mismatches++;
				end else begin
					want = awaited_results.pop_front();
					if (read_byte !== want.rd) begin
						$display("%0t: read_byte expected %02h, actual %02h",
							$time, want.rd, read_byte);
						mismatches++;
					end
					if (event_code !== want.ev) begin
						$display("%0t: event_code expected %0d, actual %0d",
							$time, want.ev, event_code);
						mismatches++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				apply_host_op(cmd, host_byte, fresh);
				awaited_results.push_back(fresh);
			end
		end
		pending = awaited_results.size();
	end

endmodule : echi_port_checker

FILE: tb/embedded_controller_host_interface_core_test.sv
// ----------------------------------------------------------------------------
// embedded_controller_host_interface_core_test: EC host interface regression
// Drives host operations into the core, first a directed walk through the
// corner cases, then randomized read/write transactions mixed with noise and
// broken sequences, under random idling on both channels. Checking is done
// by echi_port_checker; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module embedded_controller_host_interface_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import echi_pkg::*;

	localparam int TARGET_ITEMS  = 1950;
	localparam int CALM_FROM     = 1800;  // no idling on either side past this
	localparam int SQUEEZE_AT    = 500;   // item count that triggers the long hold-off
	localparam int HOLD_OFF      = 64;
	localparam int DRAIN_CYCLES  = 8;
	localparam int QUIET_LIMIT   = 4000;  // cycles without any transfer

	typedef struct {
		op_t   op;
		byte_t b;
	} host_op_t;

	logic  clk;
	logic  arst_n;
	logic  in_valid;
	logic  in_stall;
	op_t   cmd;
	byte_t host_byte;
	logic  out_valid;
	logic  out_stall;
	byte_t read_byte;
	event_t event_code;

	int mismatches;
	int pending;

	// stimulus bookkeeping shared between the sender and the receiver
	int n_items;
	int n_read_txn;
	int n_write_txn;
	int n_broken;
	int gap_odds;      // 0: no gaps, else one gap per gap_odds items on average
	bit calm;
	bit squeeze;

	host_op_t opening [28] = '{
		'{OP_STATUS_READ, 8'h00},   // status right after reset
		'{OP_DATA_READ,   8'h00},   // data read with output empty: stale buffer
		'{OP_TICK,        8'h00},   // tick with nothing pending
		'{OP_DATA_WRITE,  8'hFF},
		'{OP_TICK,        8'h00},   // data byte while idle
		'{OP_CMD_WRITE,   EC_CMD_WRITE},
		'{OP_DATA_WRITE,  8'h00},   // overrun: input still full
		'{OP_STATUS_READ, 8'h00},   // IBF and CMD set
		'{OP_TICK,        8'h00},
		'{OP_DATA_WRITE,  8'hFF},   // write address, top of RAM
		'{OP_TICK,        8'h00},
		'{OP_DATA_WRITE,  8'hA5},   // write value
		'{OP_TICK,        8'h00},
		'{OP_CMD_WRITE,   EC_CMD_WRITE},
		'{OP_TICK,        8'h00},
		'{OP_CMD_WRITE,   EC_CMD_READ},  // abandon the write, start a read
		'{OP_TICK,        8'h00},
		'{OP_DATA_WRITE,  8'hFF},
		'{OP_TICK,        8'h00},   // loads A5, sets OBF
		'{OP_CMD_WRITE,   EC_CMD_READ},
		'{OP_TICK,        8'h00},
		'{OP_DATA_WRITE,  8'h00},
		'{OP_TICK,        8'h00},   // read address with output still full
		'{OP_STATUS_READ, 8'h00},
		'{OP_DATA_READ,   8'h00},
		'{OP_CMD_WRITE,   8'h7F},
		'{OP_TICK,        8'h00},   // unknown command
		'{3'd7,           8'hFF}    // undefined operation code
	};

	embedded_controller_host_interface_core DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.host_byte  (host_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.read_byte  (read_byte),
		.event_code (event_code)
	);

	echi_port_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.host_byte  (host_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.read_byte  (read_byte),
		.event_code (event_code),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Pick an address: half the time from a small pool at both ends of the
	// RAM so that reads keep hitting bytes written earlier in the run.
	function automatic byte_t pick_addr();
		if ($urandom_range(0, 1) == 1)
			return {($urandom_range(0, 1) == 1) ? 5'h1F : 5'h00, 3'($urandom_range(0, 7))};
		return 8'($urandom);
	endfunction

	// Offer one operation and hold it until the transfer. Called at a rising
	// edge; returns at the edge on which the transfer happens.
	task automatic send_op(input op_t op, input byte_t b);
		if (!calm && !squeeze && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		cmd       <= op;
		host_byte <= b;
		// stall settles by the falling edge, so sample it there
		@(negedge clk);
		while (in_stall) @(negedge clk);
		@(posedge clk);
		n_items++;
		if (n_items >= CALM_FROM) calm = 1'b1;
	endtask

	// Sender: directed walk, then random transactions until the item target.
	initial begin
		byte_t addr;
		int    kind;
		int    n;

		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		cmd       <= OP_STATUS_READ;
		host_byte <= '0;
		n_items = 0;
		n_read_txn = 0;
		n_write_txn = 0;
		n_broken = 0;
		gap_odds = 0;
		calm = 1'b0;
		squeeze = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening[i]) send_op(opening[i].op, opening[i].b);

		while (n_items < TARGET_ITEMS) begin
			// vary the sender gap density per sequence, including none at all
			case ($urandom_range(0, 3))
				0: gap_odds = 0;
				1: gap_odds = 2;
				2: gap_odds = 4;
				default: gap_odds = 8;
			endcase
			kind = $urandom_range(0, 99);
			if (kind < 35) begin
				// well-formed RAM read, then usually fetch the byte
				addr = pick_addr();
				send_op(OP_CMD_WRITE, EC_CMD_READ);
				send_op(OP_TICK, 8'($urandom));
				send_op(OP_DATA_WRITE, addr);
				send_op(OP_TICK, 8'($urandom));
				if ($urandom_range(0, 2) == 0) send_op(OP_STATUS_READ, 8'($urandom));
				if ($urandom_range(0, 9) < 7) send_op(OP_DATA_READ, 8'($urandom));
				if ($urandom_range(0, 4) == 0) send_op(OP_DATA_READ, 8'($urandom));
				n_read_txn++;
			end else if (kind < 70) begin
				// well-formed RAM write, sometimes read back at once
				addr = pick_addr();
				send_op(OP_CMD_WRITE, EC_CMD_WRITE);
				send_op(OP_TICK, 8'($urandom));
				send_op(OP_DATA_WRITE, addr);
				send_op(OP_TICK, 8'($urandom));
				send_op(OP_DATA_WRITE, 8'($urandom));
				send_op(OP_TICK, 8'($urandom));
				if ($urandom_range(0, 2) == 0) send_op(OP_STATUS_READ, 8'($urandom));
				n_write_txn++;
				if ($urandom_range(0, 1) == 1) begin
					send_op(OP_CMD_WRITE, EC_CMD_READ);
					send_op(OP_TICK, 8'($urandom));
					send_op(OP_DATA_WRITE, addr);
					send_op(OP_TICK, 8'($urandom));
					send_op(OP_DATA_READ, 8'($urandom));
					n_read_txn++;
				end
			end else if (kind < 85) begin
				// broken sequences
				n_broken++;
				case ($urandom_range(0, 3))
					0: begin
						// pile up writes without ticks: overruns
						n = $urandom_range(2, 4);
						repeat (n) begin
							if ($urandom_range(0, 1) == 1)
								send_op(OP_CMD_WRITE, 8'($urandom));
							else
								send_op(OP_DATA_WRITE, 8'($urandom));
						end
						send_op(OP_STATUS_READ, 8'($urandom));
						send_op(OP_TICK, 8'($urandom));
					end
					1: begin
						// start a transaction, then cut it off with a new command
						send_op(OP_CMD_WRITE, ($urandom_range(0, 1) == 1) ? EC_CMD_READ
							: EC_CMD_WRITE);
						send_op(OP_TICK, 8'($urandom));
						if ($urandom_range(0, 1) == 1) begin
							send_op(OP_DATA_WRITE, pick_addr());
							send_op(OP_TICK, 8'($urandom));
						end
						send_op(OP_CMD_WRITE, ($urandom_range(0, 2) == 0) ? 8'($urandom)
							: EC_CMD_READ);
						send_op(OP_TICK, 8'($urandom));
					end
					2: begin
						// data byte with no transaction open
						send_op(OP_DATA_WRITE, 8'($urandom));
						send_op(OP_TICK, 8'($urandom));
						send_op(OP_TICK, 8'($urandom));
					end
					default: begin
						// unknown command byte, near misses included
						send_op(OP_CMD_WRITE, ($urandom_range(0, 1) == 1)
							? (EC_CMD_READ ^ (8'h1 << $urandom_range(1, 7)))
							: 8'($urandom));
						send_op(OP_TICK, 8'($urandom));
						send_op(OP_STATUS_READ, 8'($urandom));
					end
				endcase
			end else begin
				// noise: any operation code, undefined ones too
				n = $urandom_range(1, 4);
				repeat (n) send_op(op_t'($urandom_range(0, 7)), 8'($urandom));
			end
		end
		in_valid <= 1'b0;

		// drain: wait for every predicted result, then a little longer
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d host operations: %0d RAM read and %0d RAM write transactions,",
			n_items, n_read_txn, n_write_txn);
		$display("%0d broken sequences, random idling and one %0d-cycle output hold-off.",
			n_broken, HOLD_OFF);
		if (mismatches == 0 && pending == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// Receiver: random stall bursts, one long hold-off to back the core up,
	// no stalls once the run is in its final stretch.
	initial begin
		bit squeezed;

		squeezed = 1'b0;
		out_stall <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (!squeezed && n_items >= SQUEEZE_AT) begin
				// hold the output while the sender keeps offering
				squeeze = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_OFF) @(posedge clk);
				squeeze = 1'b0;
				squeezed = 1'b1;
			end else if (!calm && $urandom_range(0, 2) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
			out_stall <= 1'b0;
			// mostly short open windows, now and then a long stall-free stretch
			if ($urandom_range(0, 7) == 0)
				repeat ($urandom_range(20, 60)) @(posedge clk);
			else
				repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	// Watchdog: count cycles with no transfer on either channel.
	initial begin
		int quiet;

		quiet = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("%0t: no transfer for %0d cycles, %0d results outstanding",
					$time, quiet, pending);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

endmodule : embedded_controller_host_interface_core_test

FILE: files.f
src/echi_pkg.sv
src/embedded_controller_host_interface_core.sv
tb/echi_port_checker.sv
tb/embedded_controller_host_interface_core_test.sv
